@@ design/nts_pkg.sv @@
// Shared types and constants for the non-preemptive task scheduler.
package nts_pkg;

  localparam int ARR_W   = 16;
  localparam int BURST_W = 12;
  localparam int PRI_W   = 4;
  localparam int TIME_W  = 20;
  localparam int TIDX_W  = 5;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic run_init;
    logic scan_init;
    logic scan_step;
    logic commit;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic last;
  } sts_t;

endpackage

@@ design/nts_ctrl.sv @@
// Sequencing FSM: load, selection scan, dispatch decision and result hand-off.
module nts_ctrl
  import nts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last_task,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   out_valid_r;

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_LOAD) && in_valid;
    cmd.run_init  = cmd.load && in_last_task;
    cmd.scan_step = (state_r == ST_SCAN);
    cmd.commit    = (state_r == ST_DECIDE);
    cmd.finish    = (state_r == ST_EMIT) && !out_stall && sts.last;
    cmd.scan_init = cmd.run_init
                  || ((state_r == ST_DECIDE) && !sts.found)
                  || ((state_r == ST_EMIT) && !out_stall && !sts.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (cmd.run_init) begin
            state_r    <= ST_SCAN;
            in_stall_r <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (sts.scan_done) state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          // no task ready: time jumps to earliest arrival, scan again
          if (sts.found) begin
            state_r     <= ST_EMIT;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (sts.last) begin
              state_r    <= ST_LOAD;
              in_stall_r <= 1'b0;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

endmodule

@@ design/nts_dpath.sv @@
// Task store, scan accumulators, simulated clock and result registers.
module nts_dpath
  import nts_pkg::*;
#(
  parameter int MAX_TASKS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [MODE_W-1:0]    cfg_wdata,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [ARR_W-1:0]     in_arrival_time,
  input  logic [BURST_W-1:0]   in_burst_time,
  input  logic [PRI_W-1:0]     in_priority_level,
  output logic [TIDX_W-1:0]    out_task_index,
  output logic [TIME_W-1:0]    out_wait_time,
  output logic [TIME_W-1:0]    out_turnaround,
  output logic [TIME_W-1:0]    out_finish_time,
  output logic [TIME_W-1:0]    out_first_response,
  output logic                 out_last_result
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int EW = ARR_W + BURST_W + PRI_W;

  logic [MODE_W-1:0]  mode_r;
  logic [CW-1:0]      count_r;
  logic [EW-1:0]      mem [MAX_TASKS];
  logic [EW-1:0]      rd_data_r;
  logic [CW-1:0]      idx_r;
  logic [IW-1:0]      idx_d_r;
  logic               pend_r;
  logic [MAX_TASKS-1:0] done_r;
  logic [TIME_W-1:0]  time_r;
  logic [CW-1:0]      served_r;

  logic               fu_found_r;
  logic [IW-1:0]      fu_idx_r;
  logic [ARR_W-1:0]   fu_arr_r;
  logic [BURST_W-1:0] fu_burst_r;
  logic               sel_found_r;
  logic [IW-1:0]      sel_idx_r;
  logic [ARR_W-1:0]   sel_arr_r;
  logic [BURST_W-1:0] sel_burst_r;
  logic [BURST_W-1:0] sel_key_r;
  logic [ARR_W-1:0]   minarr_r;

  logic [TIDX_W-1:0]  res_idx_r;
  logic [TIME_W-1:0]  res_wait_r;
  logic [TIME_W-1:0]  res_tat_r;
  logic [TIME_W-1:0]  res_fin_r;
  logic               res_last_r;

  logic               rd_en;
  logic [ARR_W-1:0]   e_arr;
  logic [BURST_W-1:0] e_burst;
  logic [PRI_W-1:0]   e_pri;
  logic [BURST_W-1:0] e_key;
  logic               e_live;
  logic               e_ready;
  logic               mode_ready;
  logic               c_found;
  logic [IW-1:0]      c_idx;
  logic [ARR_W-1:0]   c_arr;
  logic [BURST_W-1:0] c_burst;
  logic [TIME_W-1:0]  c_start;
  logic [TIME_W-1:0]  c_fin;
  logic [CW-1:0]      served_inc;

  assign rd_en   = cmd.scan_step && (idx_r < count_r);
  assign e_arr   = rd_data_r[ARR_W-1:0];
  assign e_burst = rd_data_r[ARR_W +: BURST_W];
  assign e_pri   = rd_data_r[ARR_W+BURST_W +: PRI_W];
  assign e_key   = (mode_r == MODE_SJF) ? e_burst : BURST_W'(e_pri);
  assign e_live  = pend_r && !done_r[idx_d_r];
  assign e_ready = TIME_W'(e_arr) <= time_r;

  // modes 1 and 2 pick among arrived tasks; 0 and the unused code take load order
  assign mode_ready = (mode_r == MODE_SJF) || (mode_r == MODE_PRIO);
  assign c_found    = mode_ready ? sel_found_r : fu_found_r;
  assign c_idx      = mode_ready ? sel_idx_r   : fu_idx_r;
  assign c_arr      = mode_ready ? sel_arr_r   : fu_arr_r;
  assign c_burst    = mode_ready ? sel_burst_r : fu_burst_r;
  assign c_start    = (time_r < TIME_W'(c_arr)) ? TIME_W'(c_arr) : time_r;
  assign c_fin      = c_start + TIME_W'(c_burst);
  assign served_inc = served_r + CW'(1);

  assign sts.scan_done = (idx_r == count_r) && !pend_r;
  assign sts.found     = c_found;
  assign sts.last      = res_last_r;

  assign out_task_index     = res_idx_r;
  assign out_wait_time      = res_wait_r;
  assign out_turnaround     = res_tat_r;
  assign out_finish_time    = res_fin_r;
  assign out_first_response = res_wait_r;
  assign out_last_result    = res_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FCFS;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // task store
  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CW'(MAX_TASKS))) begin
      mem[count_r[IW-1:0]] <= {in_priority_level, in_burst_time, in_arrival_time};
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      count_r <= '0;
    end else if (cmd.load && (count_r < CW'(MAX_TASKS))) begin
      count_r <= count_r + CW'(1);
    end
  end

  // scan pointer, one store read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.scan_init) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.scan_step) begin
      pend_r <= rd_en;
      if (rd_en) idx_r <= idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) idx_d_r <= idx_r[IW-1:0];
  end

  // accumulators: first unfinished, best arrived, earliest pending arrival
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fu_found_r  <= 1'b0;
      sel_found_r <= 1'b0;
    end else if (cmd.scan_init) begin
      fu_found_r  <= 1'b0;
      sel_found_r <= 1'b0;
    end else if (e_live) begin
      if (!fu_found_r) fu_found_r <= 1'b1;
      if (e_ready && (!sel_found_r || (e_key < sel_key_r))) sel_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      minarr_r <= '1;
    end else if (e_live) begin
      if (!fu_found_r) begin
        fu_idx_r   <= idx_d_r;
        fu_arr_r   <= e_arr;
        fu_burst_r <= e_burst;
      end
      // strict less-than keeps the lowest index on ties
      if (e_ready && (!sel_found_r || (e_key < sel_key_r))) begin
        sel_idx_r   <= idx_d_r;
        sel_arr_r   <= e_arr;
        sel_burst_r <= e_burst;
        sel_key_r   <= e_key;
      end
      if (e_arr < minarr_r) minarr_r <= e_arr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r   <= '0;
      time_r   <= '0;
      served_r <= '0;
    end else if (cmd.run_init) begin
      done_r   <= '0;
      time_r   <= '0;
      served_r <= '0;
    end else if (cmd.commit) begin
      if (c_found) begin
        done_r[c_idx] <= 1'b1;
        time_r        <= c_fin;
        served_r      <= served_inc;
      end else begin
        time_r <= TIME_W'(minarr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_last_r <= 1'b0;
    end else if (cmd.commit && c_found) begin
      res_last_r <= (served_inc == count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && c_found) begin
      res_idx_r  <= TIDX_W'(c_idx);
      res_wait_r <= c_start - TIME_W'(c_arr);
      res_tat_r  <= c_fin - TIME_W'(c_arr);
      res_fin_r  <= c_fin;
    end
  end

endmodule

@@ design/nonpreemptive_task_scheduler_core.sv @@
// Top level of the non-preemptive task scheduler: controller plus datapath.
//
//  channel  | handshake          | transaction
//  ---------+--------------------+------------------------------------------
//  in_      | in_valid/in_stall  | one task record, last_task starts a run
//  out_     | out_valid/out_stall| one dispatch record per scheduled task
//  cfg_     | cfg_we             | sched_mode write, user must issue it while idle; unchecked
//
// Loading takes one cycle per task. After the last task the input stalls
// while the run proceeds: each dispatch is a scan of the store (one store
// read per cycle), a decide state and the output hand-off. In modes 1 and 2
// an idle gap costs an extra scan and decide pass. Synchronous active-low
// reset; no clearing pass. A stalled result holds the run until taken.
module nonpreemptive_task_scheduler_core
  import nts_pkg::*;
#(
  parameter int MAX_TASKS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [MODE_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ARR_W-1:0]   in_arrival_time,
  input  logic [BURST_W-1:0] in_burst_time,
  input  logic [PRI_W-1:0]   in_priority_level,
  input  logic               in_last_task,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TIDX_W-1:0]  out_task_index,
  output logic [TIME_W-1:0]  out_wait_time,
  output logic [TIME_W-1:0]  out_turnaround,
  output logic [TIME_W-1:0]  out_finish_time,
  output logic [TIME_W-1:0]  out_first_response,
  output logic               out_last_result
);

  cmd_t cmd;
  sts_t sts;

  nts_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_task (in_last_task),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  nts_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .sts                (sts),
    .in_arrival_time    (in_arrival_time),
    .in_burst_time      (in_burst_time),
    .in_priority_level  (in_priority_level),
    .out_task_index     (out_task_index),
    .out_wait_time      (out_wait_time),
    .out_turnaround     (out_turnaround),
    .out_finish_time    (out_finish_time),
    .out_first_response (out_first_response),
    .out_last_result    (out_last_result)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the non-preemptive task scheduler core.
module tb;
  import nts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TASKS = 32;
  // Unused mode encoding, behaves as first come first served
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [TIDX_W-1:0] idx;
    logic [TIME_W-1:0] waited;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] fin;
    logic [TIME_W-1:0] resp;
    logic              last_flag;
  } dispatch_t;

  class sched_scoreboard;
    logic [ARR_W-1:0]   arrivals[MAX_TASKS];
    logic [BURST_W-1:0] bursts[MAX_TASKS];
    logic [PRI_W-1:0]   prios[MAX_TASKS];
    int unsigned        n_loaded;
    logic [MODE_W-1:0]  mode;
    dispatch_t          dispatches[$];
    int                 errors;

    function void set_mode(logic [MODE_W-1:0] m);
      mode = m;
    endfunction

    function int pending();
      return dispatches.size();
    endfunction

    // One accepted load transaction; the last one runs the whole set
    function void note_task(logic [ARR_W-1:0] arr, logic [BURST_W-1:0] burst,
                            logic [PRI_W-1:0] pri, logic last_task);
      if (n_loaded < MAX_TASKS) begin
        arrivals[n_loaded] = arr;
        bursts[n_loaded] = burst;
        prios[n_loaded] = pri;
        n_loaded++;
      end
      if (last_task)
        schedule_set();
    endfunction

    function void schedule_set();
      bit [MAX_TASKS-1:0] done;
      int unsigned now, served, start, finish, earliest;
      int sel;
      dispatch_t d;
      done = '0;
      now = 0;
      served = 0;
      while (served < n_loaded) begin
        sel = -1;
        for (int i = 0; i < n_loaded; i++) begin
          if (done[i]) continue;
          if (mode == MODE_SJF || mode == MODE_PRIO) begin
            if (32'(arrivals[i]) > now) continue;
            if (sel < 0)
              sel = i;
            else if (mode == MODE_SJF && bursts[i] < bursts[sel])
              sel = i;
            else if (mode == MODE_PRIO && prios[i] < prios[sel])
              sel = i;
          end else begin
            sel = i;
            break;
          end
        end
        if (sel < 0) begin
          // nothing ready: jump to the next arrival
          earliest = '1;
          for (int i = 0; i < n_loaded; i++)
            if (!done[i] && 32'(arrivals[i]) < earliest) earliest = 32'(arrivals[i]);
          now = earliest;
          continue;
        end
        if (now < 32'(arrivals[sel])) now = 32'(arrivals[sel]);
        start = now;
        finish = start + 32'(bursts[sel]);
        now = finish;
        done[sel] = 1'b1;
        served++;
        d.idx = sel[TIDX_W-1:0];
        d.waited = TIME_W'(start - 32'(arrivals[sel]));
        d.tat = TIME_W'(finish - 32'(arrivals[sel]));
        d.fin = TIME_W'(finish);
        d.resp = d.waited;
        d.last_flag = (served == n_loaded);
        dispatches.push_back(d);
      end
      n_loaded = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task field_check(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
      if ($isunknown(got) || got != want)
        report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_dispatch(dispatch_t got);
      dispatch_t want;
      if (dispatches.size() == 0) begin
        report($sformatf("unexpected dispatch transaction, task_index %0d", got.idx));
        return;
      end
      want = dispatches.pop_front();
      field_check("task_index", TIME_W'(got.idx), TIME_W'(want.idx));
      field_check("wait_time", got.waited, want.waited);
      field_check("turnaround", got.tat, want.tat);
      field_check("finish_time", got.fin, want.fin);
      field_check("first_response", got.resp, want.resp);
      field_check("last_result", TIME_W'(got.last_flag), TIME_W'(want.last_flag));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [MODE_W-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ARR_W-1:0]   in_arrival_time = '0;
  logic [BURST_W-1:0] in_burst_time = '0;
  logic [PRI_W-1:0]   in_priority_level = '0;
  logic               in_last_task = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TIDX_W-1:0]  out_task_index;
  logic [TIME_W-1:0]  out_wait_time;
  logic [TIME_W-1:0]  out_turnaround;
  logic [TIME_W-1:0]  out_finish_time;
  logic [TIME_W-1:0]  out_first_response;
  logic               out_last_result;

  sched_scoreboard sb = new();
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  logic rcv_hold = 1'b0;
  int  tasks_stored = 0;

  nonpreemptive_task_scheduler_core #(.MAX_TASKS(MAX_TASKS)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_arrival_time(in_arrival_time), .in_burst_time(in_burst_time),
    .in_priority_level(in_priority_level), .in_last_task(in_last_task),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_task_index(out_task_index), .out_wait_time(out_wait_time),
    .out_turnaround(out_turnaround), .out_finish_time(out_finish_time),
    .out_first_response(out_first_response), .out_last_result(out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Dispatch side: check each accepted transaction, then choose next stall
  always @(posedge clk) begin
    dispatch_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.idx = out_task_index;
      got.waited = out_wait_time;
      got.tat = out_turnaround;
      got.fin = out_finish_time;
      got.resp = out_first_response;
      got.last_flag = out_last_result;
      sb.check_dispatch(got);
    end
    out_stall <= rcv_hold || ($urandom_range(99) < rcv_idle_pct);
  end

  task send_task(logic [ARR_W-1:0] arr, logic [BURST_W-1:0] burst,
                 logic [PRI_W-1:0] pri, logic last_task);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_arrival_time <= arr;
    in_burst_time <= burst;
    in_priority_level <= pri;
    in_last_task <= last_task;
    do @(posedge clk); while (in_stall);
    sb.note_task(arr, burst, pri, last_task);
    if (sb.n_loaded != 0 || last_task) tasks_stored++;
  endtask

  // Mode changes only once the block has drained and settled
  task write_mode(logic [MODE_W-1:0] m);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  task send_random_set(int size);
    int span_sel, burst_sel;
    int unsigned span;
    logic [ARR_W-1:0] arr;
    logic [BURST_W-1:0] burst;
    span_sel = $urandom_range(99);
    if (span_sel < 60) span = 8 * size;
    else if (span_sel < 85) span = 2000;
    else span = 65535;
    for (int i = 0; i < size; i++) begin
      arr = ARR_W'($urandom_range(span, 0));
      burst_sel = $urandom_range(99);
      if (burst_sel < 75) burst = BURST_W'($urandom_range(40, 1));
      else if (burst_sel < 95) burst = BURST_W'($urandom_range(4095, 1));
      else burst = '0;
      send_task(arr, burst, PRI_W'($urandom_range(15, 0)), i == size - 1);
    end
  endtask

  task random_sets(int target);
    int size_sel, size;
    while (tasks_stored < target) begin
      if ($urandom_range(1) == 1) write_mode(MODE_W'($urandom_range(3, 0)));
      size_sel = $urandom_range(99);
      if (size_sel < 70) size = $urandom_range(8, 1);
      else if (size_sel < 92) size = $urandom_range(MAX_TASKS, 9);
      else size = $urandom_range(MAX_TASKS + 4, MAX_TASKS + 1);  // overflow drops
      send_random_set(size);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 23;
    rcv_idle_pct = 71;
    write_mode(MODE_FCFS);
    send_task(16'hFFFF, 12'hFFF, 4'hF, 1'b0);
    send_task(16'h0000, 12'd1, 4'h0, 1'b1);
    send_task(16'd7, 12'd0, 4'd9, 1'b1);      // zero burst, lone task

    write_mode(MODE_SJF);
    send_task(16'd0, 12'd5, 4'd3, 1'b0);
    send_task(16'd0, 12'd2, 4'd1, 1'b0);
    send_task(16'd0, 12'd2, 4'd0, 1'b0);      // burst tie, lower index wins
    send_task(16'd100, 12'd1, 4'd0, 1'b1);    // idle gap before this one

    write_mode(MODE_PRIO);
    send_task(16'd3, 12'd5, 4'd3, 1'b0);
    send_task(16'd0, 12'd2, 4'd1, 1'b0);
    send_task(16'd0, 12'd9, 4'd1, 1'b0);
    send_task(16'd40, 12'd1, 4'd0, 1'b1);

    write_mode(MODE_SPARE);
    send_task(16'd10, 12'd3, 4'd0, 1'b0);
    send_task(16'd0, 12'd1, 4'd15, 1'b0);
    send_task(16'd5, 12'd2, 4'd0, 1'b1);

    random_sets(100);

    snd_idle_pct = 71;
    rcv_idle_pct = 23;
    random_sets(190);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // long hold-off on the dispatch side while loads keep coming
    fork
      begin
        rcv_hold <= 1'b1;
        repeat (600) @(posedge clk);
        rcv_hold <= 1'b0;
      end
      begin
        send_random_set(MAX_TASKS);
        send_random_set(6);
      end
    join
    random_sets(250);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout, %0d dispatch transactions outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
design/nts_pkg.sv
design/nts_ctrl.sv
design/nts_dpath.sv
design/nonpreemptive_task_scheduler_core.sv
tb/tb.sv
